[src/birq_pkg.sv]
// ---------------------------------------------------------------------------
// birq_pkg: shared types and constants of the banked interrupt scan unit
// Action codes, line and digit widths, and the scanner status record.
// ---------------------------------------------------------------------------
package birq_pkg;

	localparam int ACTION_W = 2;
	localparam int LINE_W   = 7;
	localparam int START_W  = 8;
	localparam int DIGIT_W  = 8;
	localparam int DIGIT_SH = 3;
	localparam int RAW_BASIC_W = 8;
	localparam int BANK_LINES  = 32;

	localparam logic [ACTION_W-1:0] ACT_MASK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_UNMASK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

	// Scanner report to the control logic.
	typedef struct packed {
		logic              done;
		logic              found;
		logic [LINE_W-1:0] line;
	} scan_status_t;

endpackage

[src/birq_enable.sv]
// ---------------------------------------------------------------------------
// birq_enable: per-line enable bits
// Holds one enable bit per line, applies mask and unmask writes, and gates
// the raw request lines into a flat pending vector indexed by line number.
// ---------------------------------------------------------------------------
module birq_enable #(
	parameter int BASIC_LINES = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr,
	input  logic                                   set,
	input  logic [birq_pkg::LINE_W-1:0]            target,
	input  logic [birq_pkg::RAW_BASIC_W-1:0]       raw_basic,
	input  logic [birq_pkg::BANK_LINES-1:0]        raw_bank_one,
	input  logic [birq_pkg::BANK_LINES-1:0]        raw_bank_two,
	output logic [BASIC_LINES+2*birq_pkg::BANK_LINES-1:0] pend
);
	import birq_pkg::*;

	localparam int TOTAL = BASIC_LINES + 2 * BANK_LINES;

	logic [TOTAL-1:0] en_q;
	logic [TOTAL-1:0] raw_flat;

	// Out-of-range targets match no line and so change nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (wr) begin
			for (int n = 0; n < TOTAL; n++) begin
				if (target == LINE_W'(n)) en_q[n] <= set;
			end
		end
	end

	for (genvar n = 0; n < BASIC_LINES; n++) begin : g_basic
		if (n < RAW_BASIC_W) begin : g_raw
			assign raw_flat[n] = raw_basic[n];
		end else begin : g_none
			assign raw_flat[n] = 1'b0;
		end
	end

	assign raw_flat[BASIC_LINES +: BANK_LINES]              = raw_bank_one;
	assign raw_flat[BASIC_LINES + BANK_LINES +: BANK_LINES] = raw_bank_two;

	assign pend = raw_flat & en_q;

endmodule

[src/birq_scan.sv]
// ---------------------------------------------------------------------------
// birq_scan: digit-serial next-pending search
// Shifts the pending vector out one byte per cycle and stops at the lowest
// pending line at or above the start line.
// ---------------------------------------------------------------------------
module birq_scan #(
	parameter int BASIC_LINES = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [BASIC_LINES+2*birq_pkg::BANK_LINES-1:0] pend,
	input  logic [birq_pkg::START_W-1:0]           start_line,
	output birq_pkg::scan_status_t                 status
);
	import birq_pkg::*;

	localparam int TOTAL = BASIC_LINES + 2 * BANK_LINES;
	localparam int NDIG  = (TOTAL + DIGIT_W - 1) / DIGIT_W;
	localparam int DIG_W = $clog2(NDIG);
	localparam int PAD_W = NDIG * DIGIT_W;

	logic [PAD_W-1:0]   shreg_q;
	logic [DIG_W-1:0]   dig_q;
	logic               run_q;
	logic [START_W-1:0] start_q;

	logic [START_W-1:0] base;
	logic [START_W-1:0] idx;
	logic               hit;
	logic [START_W-1:0] hit_line;
	logic               last_dig;

	assign base     = START_W'(dig_q) << DIGIT_SH;
	assign last_dig = (dig_q == DIG_W'(NDIG - 1));

	// Lowest eligible bit of the current digit wins.
	always_comb begin
		hit      = 1'b0;
		hit_line = '0;
		idx      = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			idx = base + START_W'(i);
			if (shreg_q[i] && idx >= start_q) begin
				hit      = 1'b1;
				hit_line = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			dig_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			dig_q <= '0;
		end else if (run_q) begin
			if (hit || last_dig) run_q <= 1'b0;
			else                 dig_q <= dig_q + DIG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shreg_q <= PAD_W'(pend);
			start_q <= start_line;
		end else if (run_q) begin
			shreg_q <= shreg_q >> DIGIT_W;
		end
	end

	assign status.done  = run_q && (hit || last_dig);
	assign status.found = run_q && hit;
	assign status.line  = hit ? hit_line[LINE_W-1:0] : '0;

endmodule

[src/banked_irq_next_pending_scan_unit.sv]
// ---------------------------------------------------------------------------
// banked_irq_next_pending_scan_unit: banked interrupt controller, top level
// Keeps an enable bit per line over the basic bank and two 32-line banks,
// masks and unmasks lines, and searches for the next pending enabled line.
// ---------------------------------------------------------------------------
//
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------------------------
// input     start / busy       action, target_line, last_found, raw_basic,
//                              raw_bank_one, raw_bank_two
// result    done (one cycle)   found, next_line, invalid_line
//
// An item is taken on a rising edge with start high and busy low.
// Mask, unmask and the unused action: result in the cycle after the item is
// taken, busy stays low, so a new item may follow at once.
// Query: the pending vector is scanned one byte per cycle, lowest line first,
// and the result is registered from the scanner's report; busy is high until
// the cycle that shows the result, and the next item may be taken at its end.
// Reset clears every enable bit (all lines disabled) and idles the scanner.
// The receiver cannot stall: each result shows on done for one cycle only.
// ---------------------------------------------------------------------------
module banked_irq_next_pending_scan_unit #(
	parameter int BASIC_LINES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [birq_pkg::ACTION_W-1:0]     action,
	input  logic [birq_pkg::LINE_W-1:0]       target_line,
	input  logic signed [birq_pkg::START_W-1:0] last_found,
	input  logic [birq_pkg::RAW_BASIC_W-1:0]  raw_basic,
	input  logic [birq_pkg::BANK_LINES-1:0]   raw_bank_one,
	input  logic [birq_pkg::BANK_LINES-1:0]   raw_bank_two,
	output logic                              done,
	output logic                              found,
	output logic [birq_pkg::LINE_W-1:0]       next_line,
	output logic                              invalid_line
);
	import birq_pkg::*;

	localparam int TOTAL = BASIC_LINES + 2 * BANK_LINES;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	logic               accept;
	logic               is_write;
	logic               is_query;
	logic               out_of_range;
	logic [START_W-1:0] start_line;
	logic [TOTAL-1:0]   pend;
	scan_status_t       status;

	logic               done_q;
	logic               found_q;
	logic [LINE_W-1:0]  next_line_q;
	logic               invalid_q;

	assign busy     = (state_q == ST_SCAN);
	assign accept   = start && !busy;
	assign is_write = (action == ACT_MASK) || (action == ACT_UNMASK);
	assign is_query = (action == ACT_QUERY);

	// Lines past the last bank are rejected; the decode in the enable file
	// ignores them anyway, this only raises the flag.
	assign out_of_range = (START_W'(target_line) >= START_W'(TOTAL));

	// Search starts one above the last line found; negative means line 0.
	assign start_line = last_found[START_W-1] ? '0 : START_W'(last_found + 8'sd1);

	birq_enable #(
		.BASIC_LINES(BASIC_LINES)
	) u_enable (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (accept && is_write),
		.set         (action == ACT_UNMASK),
		.target      (target_line),
		.raw_basic   (raw_basic),
		.raw_bank_one(raw_bank_one),
		.raw_bank_two(raw_bank_two),
		.pend        (pend)
	);

	// Pending lines are captured at the edge that takes the query, so the
	// scan sees the enables as they stood before any later write.
	birq_scan #(
		.BASIC_LINES(BASIC_LINES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && is_query),
		.pend      (pend),
		.start_line(start_line),
		.status    (status)
	);

	// Control: hold in SCAN until the scanner reports, then drop back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_query) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: the strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !is_query) || (busy && status.done);
		end
	end

	always_ff @(posedge clk) begin
		if (busy && status.done) begin
			found_q     <= status.found;
			next_line_q <= status.line;
			invalid_q   <= 1'b0;
		end else if (accept && !is_query) begin
			found_q     <= 1'b0;
			next_line_q <= '0;
			invalid_q   <= is_write && out_of_range;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign next_line    = next_line_q;
	assign invalid_line = invalid_q;

endmodule

[src/birq_chk.sv]
// ---------------------------------------------------------------------------
// birq_chk: port-level checks of the banked interrupt scan unit
// Watches the handshake and the result fields over time.
// ---------------------------------------------------------------------------
module birq_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [birq_pkg::ACTION_W-1:0]     action,
	input  logic                              done,
	input  logic                              found,
	input  logic [birq_pkg::LINE_W-1:0]       next_line,
	input  logic                              invalid_line
);
	import birq_pkg::*;

	// A result always arrives with the unit free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A result with a found line never carries the invalid flag.
	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> !invalid_line)
		else $error("found and invalid_line together");

	// No line found reads as line zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (next_line == '0))
		else $error("next_line not zero without a find");

	// Mask, unmask and the unused action answer in the next cycle.
	a_write_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_QUERY) |=> (done && !found && !busy))
		else $error("missing one-cycle reply to a write");

endmodule

bind banked_irq_next_pending_scan_unit birq_chk u_birq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.done        (done),
	.found       (found),
	.next_line   (next_line),
	.invalid_line(invalid_line)
);
